@@ sv/expression_token_lexer_unit_defines.svh @@
// Assertion macros shared by the expression token lexer RTL.
`ifndef EXPRESSION_TOKEN_LEXER_UNIT_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_UNIT_DEFINES_SVH
`ifndef SYNTH
// Condition must hold at every clock edge out of reset.
`define ETL_ASSERT_HOLD(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("etl: invariant violated");
// Consequent must hold in the cycle after the antecedent.
`define ETL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etl: sequence check failed");
`else
`define ETL_ASSERT_HOLD(lbl, cond)
`define ETL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/etl_pkg.sv @@
// Types and constants shared by the expression token lexer modules.
`timescale 1ns / 1ps
package etl_pkg;

    localparam int POS_BITS  = 16;
    localparam int OUT_W     = 16;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [7:0] CH_E_LO  = "e";
    localparam logic [7:0] CH_E_UP  = "E";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_EQ    = "=";

    typedef enum logic [3:0] {
        K_NUMBER    = 4'd0,
        K_IDENT     = 4'd1,
        K_OPERATOR  = 4'd2,
        K_ASSIGN    = 4'd3,
        K_PRECISION = 4'd4,
        K_LPAREN    = 4'd5,
        K_RPAREN    = 4'd6,
        K_LBRACKET  = 4'd7,
        K_RBRACKET  = 4'd8,
        K_SEMICOLON = 4'd9,
        K_COMMA     = 4'd10,
        K_ERROR     = 4'd11,
        K_EOF       = 4'd12
    } kind_t;

    // Byte class flags worked out by the front end.
    typedef struct packed {
        logic  space;
        logic  digit;
        logic  word_start;
        logic  word;
        logic  dot;
        logic  expo;
        logic  sign;
        logic  eq;
        logic  colon;
        logic  cmp;
        logic  single;
        kind_t single_kind;
    } cls_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        cls_t       cls;
    } item_t;

    typedef struct packed {
        kind_t            kind;
        logic [OUT_W-1:0] start_pos;
        logic [OUT_W-1:0] tok_len;
        logic [7:0]       first_char;
        logic [7:0]       second_char;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [RES_CW-1:0] res_count;
        logic              pop;
        logic              pop_end;
        logic              at_rest;
    } back_stat_t;

endpackage

@@ sv/etl_if.sv @@
// Request channels of the expression token lexer: source bytes in, tokens out.
`timescale 1ns / 1ps
interface etl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink (input valid, input ch, input is_end, output ready);
endinterface

interface etl_out_if;
    logic                         valid;
    logic                         ready;
    etl_pkg::kind_t               kind;
    logic [etl_pkg::OUT_W-1:0]    start_pos;
    logic [etl_pkg::OUT_W-1:0]    tok_len;
    logic [7:0]                   first_char;
    logic [7:0]                   second_char;
    logic                         last;

    modport source (output valid, output kind, output start_pos, output tok_len,
                    output first_char, output second_char, output last, input ready);
    modport sink (input valid, input kind, input start_pos, input tok_len,
                  input first_char, input second_char, input last, output ready);
endinterface

@@ sv/etl_front.sv @@
// Front end: accepts source bytes and classifies them into queue items.
`timescale 1ns / 1ps
module etl_front (
    etl_in_if.sink          byte_ch,
    input  logic            q_full,
    output logic            q_push,
    output etl_pkg::item_t  q_item
);
    import etl_pkg::*;

    cls_t cls;
    logic [7:0] ch;

    assign ch = byte_ch.ch;

    always_comb
    begin
        cls             = '0;
        cls.single_kind = K_OPERATOR;
        cls.space       = (ch == " ") || (ch inside {[8'd9:8'd13]});
        cls.digit       = ch inside {["0":"9"]};
        cls.word_start  = (ch inside {["a":"z"], ["A":"Z"]}) || (ch == CH_UNDER);
        cls.word        = cls.word_start || cls.digit;
        cls.dot         = (ch == CH_DOT);
        cls.expo        = (ch == CH_E_LO) || (ch == CH_E_UP);
        cls.sign        = (ch == "+") || (ch == "-");
        cls.eq          = (ch == CH_EQ);
        cls.colon       = (ch == CH_COLON);
        cls.cmp         = ch inside {CH_EQ, "<", ">", "!"};
        case (ch)
            "(":
            begin
                cls.single      = 1'b1;
                cls.single_kind = K_LPAREN;
            end
            ")":
            begin
                cls.single      = 1'b1;
                cls.single_kind = K_RPAREN;
            end
            "[":
            begin
                cls.single      = 1'b1;
                cls.single_kind = K_LBRACKET;
            end
            "]":
            begin
                cls.single      = 1'b1;
                cls.single_kind = K_RBRACKET;
            end
            ";":
            begin
                cls.single      = 1'b1;
                cls.single_kind = K_SEMICOLON;
            end
            ",":
            begin
                cls.single      = 1'b1;
                cls.single_kind = K_COMMA;
            end
            "+", "-", "*", "/", "^", "%":
            begin
                cls.single      = 1'b1;
                cls.single_kind = K_OPERATOR;
            end
            default:
            begin
                cls.single      = 1'b0;
            end
        endcase
    end

    assign byte_ch.ready = !q_full;
    assign q_push        = byte_ch.valid && !q_full;

    // A zero byte ends the text just like the end marker.
    assign q_item.ch  = ch;
    assign q_item.fin = byte_ch.is_end || (ch == 8'd0);
    assign q_item.cls = cls;

endmodule

@@ sv/etl_fifo.sv @@
// Short queue of classified bytes between the front end and the lexer core.
`timescale 1ns / 1ps
module etl_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  etl_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output etl_pkg::item_t  head
);
    import etl_pkg::*;

    item_t             mem [Q_DEPTH];
    logic [Q_AW-1:0]   wptr_reg, wptr_next;
    logic [Q_AW-1:0]   rptr_reg, rptr_next;
    logic [Q_CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/etl_back.sv @@
// Lexer core: token state machine and result buffer driving the token channel.
`timescale 1ns / 1ps
module etl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  etl_pkg::item_t      head,
    output logic                pop,
    etl_out_if.source           token_ch,
    output etl_pkg::back_stat_t stat
);
    import etl_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_NUMBER,
        M_IDENT,
        M_COLON,
        M_CMP,
        M_DRAIN
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic                 seen_dot_reg, seen_dot_next;
    logic                 seen_exp_reg, seen_exp_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [POS_BITS-1:0]  tstart_reg, tstart_next;
    logic [7:0]           pfirst_reg, pfirst_next;
    logic [7:0]           psecond_reg, psecond_next;

    res_t                 res_mem [RES_DEPTH];
    logic [RES_AW-1:0]    wptr_reg, wptr_next;
    logic [RES_AW-1:0]    rptr_reg, rptr_next;
    logic [RES_CW-1:0]    count_reg, count_next;

    res_t                 flush_res, res_a, res_b, slot0, slot1;
    logic                 flush_v, a_v, b_v, taken, rd, we0, we1;
    logic [1:0]           wr_n;
    cls_t                 cls;
    logic [7:0]           ch;

    assign cls = head.cls;
    assign ch  = head.ch;

    // Take an item only while the buffer has room for both of its results.
    assign pop = head_valid && (count_reg <= RES_CW'(RES_DEPTH - 2));

    always_comb
    begin
        flush_v               = (mode_reg == M_NUMBER) || (mode_reg == M_IDENT) ||
                                (mode_reg == M_COLON) || (mode_reg == M_CMP);
        flush_res.start_pos   = OUT_W'(tstart_reg);
        flush_res.first_char  = pfirst_reg;
        flush_res.last        = 1'b0;
        flush_res.kind        = K_OPERATOR;
        flush_res.tok_len     = OUT_W'(1);
        flush_res.second_char = 8'd0;
        case (mode_reg)
            M_NUMBER, M_IDENT:
            begin
                flush_res.kind        = (mode_reg == M_NUMBER) ? K_NUMBER : K_IDENT;
                flush_res.tok_len     = OUT_W'(pos_reg - tstart_reg);
                flush_res.second_char = psecond_reg;
            end
            M_COLON:
            begin
                flush_res.kind = K_ERROR;
            end
            default:
            begin
                flush_res.kind = K_OPERATOR;
            end
        endcase
    end

    always_comb
    begin
        mode_next     = mode_reg;
        seen_dot_next = seen_dot_reg;
        seen_exp_next = seen_exp_reg;
        pos_next      = pos_reg;
        tstart_next   = tstart_reg;
        pfirst_next   = pfirst_reg;
        psecond_next  = psecond_reg;
        a_v           = 1'b0;
        b_v           = 1'b0;
        res_a         = flush_res;
        res_b         = '{kind: K_EOF, start_pos: OUT_W'(pos_reg), tok_len: '0,
                          first_char: 8'd0, second_char: 8'd0, last: 1'b1};
        taken         = 1'b0;

        if (head.fin)
        begin
            // Flush, report end of text, then return to the reset state.
            a_v           = flush_v;
            b_v           = 1'b1;
            mode_next     = M_IDLE;
            seen_dot_next = 1'b0;
            seen_exp_next = 1'b0;
            pos_next      = '0;
            tstart_next   = '0;
            pfirst_next   = 8'd0;
            psecond_next  = 8'd0;
        end
        else
        begin
            case (mode_reg)
                M_NUMBER:
                begin
                    if (cls.dot && !seen_dot_reg && !seen_exp_reg)
                    begin
                        seen_dot_next = 1'b1;
                    end
                    if (cls.expo && !seen_exp_reg)
                    begin
                        seen_exp_next = 1'b1;
                    end
                    taken = cls.digit || (cls.dot && !seen_dot_reg && !seen_exp_reg) ||
                            (cls.expo && !seen_exp_reg) || (cls.sign && seen_exp_reg);
                end
                M_IDENT:
                begin
                    taken = cls.word;
                end
                M_COLON:
                begin
                    taken = 1'b1;
                    a_v   = 1'b1;
                    if (cls.eq || cls.colon)
                    begin
                        res_a.kind        = cls.eq ? K_ASSIGN : K_PRECISION;
                        res_a.tok_len     = OUT_W'(2);
                        res_a.second_char = ch;
                        mode_next         = M_IDLE;
                    end
                    else
                    begin
                        mode_next = M_DRAIN;
                    end
                end
                M_CMP:
                begin
                    if (cls.eq)
                    begin
                        taken             = 1'b1;
                        a_v               = 1'b1;
                        res_a.kind        = K_OPERATOR;
                        res_a.tok_len     = OUT_W'(2);
                        res_a.second_char = ch;
                        mode_next         = M_IDLE;
                    end
                end
                M_DRAIN:
                begin
                    taken = 1'b1;
                end
                default:
                begin
                    taken = 1'b0;
                end
            endcase

            if (taken)
            begin
                if (((mode_reg == M_NUMBER) || (mode_reg == M_IDENT)) &&
                    (psecond_reg == 8'd0))
                begin
                    psecond_next = ch;
                end
            end
            else
            begin
                // Close the pending token and start on this byte.
                a_v               = flush_v;
                mode_next         = M_IDLE;
                res_b.start_pos   = OUT_W'(pos_reg);
                res_b.tok_len     = OUT_W'(1);
                res_b.first_char  = ch;
                res_b.second_char = 8'd0;
                if (cls.digit || cls.word_start || cls.colon || cls.cmp)
                begin
                    tstart_next   = pos_reg;
                    pfirst_next   = ch;
                    psecond_next  = 8'd0;
                    seen_dot_next = 1'b0;
                    seen_exp_next = 1'b0;
                    if (cls.digit)
                    begin
                        mode_next = M_NUMBER;
                    end
                    else if (cls.word_start)
                    begin
                        mode_next = M_IDENT;
                    end
                    else if (cls.colon)
                    begin
                        mode_next = M_COLON;
                    end
                    else
                    begin
                        mode_next = M_CMP;
                    end
                end
                else if (cls.single)
                begin
                    b_v        = 1'b1;
                    res_b.kind = cls.single_kind;
                end
                else if (!cls.space)
                begin
                    b_v        = 1'b1;
                    res_b.kind = K_ERROR;
                    mode_next  = M_DRAIN;
                end
            end

            pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        end
    end

    // Pack the results of this item into consecutive buffer slots.
    always_comb
    begin
        slot0      = a_v ? res_a : res_b;
        slot0.last = !(a_v && b_v);
        slot1      = res_b;
        slot1.last = 1'b1;
        we0        = pop && (a_v || b_v);
        we1        = pop && a_v && b_v;
        wr_n       = {1'b0, we0} + {1'b0, we1};
        rd         = token_ch.valid && token_ch.ready;
        wptr_next  = wptr_reg + RES_AW'(wr_n);
        rptr_next  = rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + RES_CW'(wr_n) - RES_CW'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            seen_dot_reg <= 1'b0;
            seen_exp_reg <= 1'b0;
            pos_reg      <= '0;
            tstart_reg   <= '0;
            pfirst_reg   <= 8'd0;
            psecond_reg  <= 8'd0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg     <= mode_next;
                seen_dot_reg <= seen_dot_next;
                seen_exp_reg <= seen_exp_next;
                pos_reg      <= pos_next;
                tstart_reg   <= tstart_next;
                pfirst_reg   <= pfirst_next;
                psecond_reg  <= psecond_next;
            end
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            res_mem[wptr_reg] <= slot0;
        end
        if (we1)
        begin
            res_mem[wptr_reg + 1'b1] <= slot1;
        end
    end

    assign token_ch.valid       = (count_reg != '0);
    assign token_ch.kind        = res_mem[rptr_reg].kind;
    assign token_ch.start_pos   = res_mem[rptr_reg].start_pos;
    assign token_ch.tok_len     = res_mem[rptr_reg].tok_len;
    assign token_ch.first_char  = res_mem[rptr_reg].first_char;
    assign token_ch.second_char = res_mem[rptr_reg].second_char;
    assign token_ch.last        = res_mem[rptr_reg].last;

    assign stat.res_count = count_reg;
    assign stat.pop       = pop;
    assign stat.pop_end   = pop && head.fin;
    assign stat.at_rest   = (mode_reg == M_IDLE) && (pos_reg == '0);

endmodule

@@ sv/expression_token_lexer_unit.sv @@
// Expression token lexer: source bytes in, tokens with kind, position and
// leading characters out.
//
// byte_ch takes one source byte per request (ch, is_end); a zero byte or
// is_end ends the text. token_ch gives one token per request; each byte
// yields zero, one or two tokens, and last marks the final token of a byte.
// End of text flushes a pending token, emits EOF and restarts at offset 0.
//
// A byte is taken every cycle while the four-entry byte queue has room.
// The lexer core consumes one byte per cycle whenever its four-entry token
// buffer has two free slots, so the sustained rate is one byte per clock
// as long as bytes yield at most one token each; two-token bytes are bound
// by the single token port. A byte is registered first in the byte queue,
// then its tokens in the token buffer.
// When token_ch stalls, the token buffer fills, the core stops and the byte
// queue then fills and drops byte_ch.ready. Reset empties both queues and
// clears the lexer state; no clearing pass is needed.
`timescale 1ns / 1ps
`include "expression_token_lexer_unit_defines.svh"
module expression_token_lexer_unit (
    input  logic       clk,
    input  logic       rst_n,
    etl_in_if.sink     byte_ch,
    etl_out_if.source  token_ch
);
    import etl_pkg::*;

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    item_t      q_in;
    item_t      q_head;
    back_stat_t stat;

    etl_front u_front (
        .byte_ch (byte_ch),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in)
    );

    etl_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    etl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .token_ch   (token_ch),
        .stat       (stat)
    );

    `ETL_ASSERT_HOLD(a_res_bound, stat.res_count <= RES_CW'(RES_DEPTH))
    `ETL_ASSERT_HOLD(a_out_valid, token_ch.valid == (stat.res_count != '0))
    `ETL_ASSERT_HOLD(a_pop_room, !stat.pop || (stat.res_count <= RES_CW'(RES_DEPTH - 2)))
    `ETL_ASSERT_NEXT(a_end_rest, stat.pop_end, stat.at_rest)

endmodule
